// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the token bucket shaper.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must never hold outside reset.
`define ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// ===== rtl/tbps_pkg.sv =====
// Package for the token bucket shaper: sizes, event codes, payload types.
// No dependencies; used by tbps_ctrl and token_bucket_packet_shaper.
package tbps_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int MAX_RELEASES = 16;
  localparam int PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int REL_W        = $clog2(MAX_RELEASES + 1);
  localparam int ID_W         = 16;
  localparam int TOK_W        = 16;
  localparam int ENTRY_W      = ID_W + TOK_W;
  localparam logic [TOK_W-1:0] DEPTH_RESET = 16'd10;

  typedef enum logic [2:0] {
    EV_QUEUED     = 3'd0,
    EV_RELEASED   = 3'd1,
    EV_DROP_LARGE = 3'd2,
    EV_DROP_FULL  = 3'd3,
    EV_TOKEN_ADD  = 3'd4,
    EV_TOKEN_DROP = 3'd5
  } tbps_ev_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_TICK
  } tbps_state_t;

  typedef struct packed {
    logic             kind;
    logic [ID_W-1:0]  packet_id;
    logic [TOK_W-1:0] tokens_needed;
  } tbps_in_t;

  typedef struct packed {
    logic [2:0]       event_res;
    logic [ID_W-1:0]  out_packet_id;
    logic [TOK_W-1:0] tokens_left;
    logic             last;
  } tbps_out_t;

  // One waiting packet as stored in the queue memory.
  typedef struct packed {
    logic [TOK_W-1:0] need;
    logic [ID_W-1:0]  id;
  } tbps_entry_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    tbps_entry_t      wdata;
    logic [PTR_W-1:0] raddr;
  } tbps_mem_req_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/tbps_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tbps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tbps_ctrl.sv =====
// Control of the token bucket shaper: token count, queue pointers, sequencer.
// Depends on tbps_pkg; drives the queue memory held in tbps_ram.
module tbps_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  tbps_pkg::tbps_in_t     in_req,
  output logic                   out_strobe,
  output tbps_pkg::tbps_out_t    out_res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [15:0]            cfg_data,
  output tbps_pkg::tbps_mem_req_t mem_req,
  input  tbps_pkg::tbps_entry_t  mem_rdata
);
  import tbps_pkg::*;

  tbps_state_t      state_r, state_nxt;
  logic [TOK_W-1:0] tok_r, tok_nxt;
  logic [TOK_W-1:0] depth_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REL_W-1:0] rel_r, rel_nxt;
  tbps_ev_t         pend_ev_r, pend_ev_nxt;
  logic [ID_W-1:0]  pend_id_r, pend_id_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  tbps_out_t        out_res_r, out_res_nxt;
  logic             head_fits;

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  // The head entry may leave only if one is waiting, its need is covered and the tick release limit is not reached.
  assign head_fits = (cnt_r != '0) && (rel_r < REL_W'(MAX_RELEASES)) &&
                     (mem_rdata.need <= tok_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tok_r        <= '0;
      depth_r      <= DEPTH_RESET;
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      rel_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tok_r        <= tok_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      cnt_r        <= cnt_nxt;
      rel_r        <= rel_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        depth_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_ev_r <= pend_ev_nxt;
    pend_id_r <= pend_id_nxt;
    out_res_r <= out_res_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    tok_nxt        = tok_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    rel_nxt        = rel_r;
    pend_ev_nxt    = pend_ev_r;
    pend_id_nxt    = pend_id_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    mem_req        = '0;
    mem_req.raddr  = head_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!in_req.kind) begin
            out_strobe_nxt            = 1'b1;
            out_res_nxt.out_packet_id = in_req.packet_id;
            out_res_nxt.last          = 1'b1;
            priority if (in_req.tokens_needed > depth_r) begin
              out_res_nxt.event_res = EV_DROP_LARGE;
            end else if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
              out_res_nxt.event_res = EV_DROP_FULL;
            end else begin
              mem_req.we         = 1'b1;
              mem_req.waddr      = tail_r;
              mem_req.wdata.need = in_req.tokens_needed;
              mem_req.wdata.id   = in_req.packet_id;
              tail_nxt           = next_ptr(tail_r);
              // A lone packet that fits leaves at once and never counts as queued.
              if ((cnt_r == '0) && (tok_r >= in_req.tokens_needed)) begin
                tok_nxt               = tok_r - in_req.tokens_needed;
                head_nxt              = next_ptr(head_r);
                out_res_nxt.event_res = EV_RELEASED;
              end else begin
                cnt_nxt               = cnt_r + CNT_W'(1);
                out_res_nxt.event_res = EV_QUEUED;
              end
            end
            out_res_nxt.tokens_left = tok_nxt;
          end else begin
            if (tok_r >= depth_r) begin
              pend_ev_nxt = EV_TOKEN_DROP;
            end else begin
              tok_nxt     = tok_r + TOK_W'(1);
              pend_ev_nxt = EV_TOKEN_ADD;
            end
            pend_id_nxt = '0;
            rel_nxt     = '0;
            state_nxt   = ST_TICK;
          end
        end
      end
      ST_TICK: begin
        // Emit the previous event; last is known once the head is checked.
        out_strobe_nxt            = 1'b1;
        out_res_nxt.event_res     = pend_ev_r;
        out_res_nxt.out_packet_id = pend_id_r;
        out_res_nxt.tokens_left   = tok_r;
        out_res_nxt.last          = !head_fits;
        if (head_fits) begin
          tok_nxt       = tok_r - mem_rdata.need;
          head_nxt      = next_ptr(head_r);
          cnt_nxt       = cnt_r - CNT_W'(1);
          rel_nxt       = rel_r + REL_W'(1);
          pend_ev_nxt   = EV_RELEASED;
          pend_id_nxt   = mem_rdata.id;
          mem_req.raddr = next_ptr(head_r);
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/token_bucket_packet_shaper.sv =====
// Top level of the token bucket shaper: control sequencer plus queue memory.
// Depends on tbps_pkg, tbps_ctrl, tbps_ram and assert_macros.svh.
//
// Usage:
//   Input: drive in_req and raise start; the request is taken at an edge where
//   busy is low. kind 0 is a packet arrival, kind 1 a token tick.
//   Results: each result sits on out_res for one cycle with out_strobe high;
//   the receiver cannot stall, so every strobed cycle must be captured.
//   out_res.last marks the final result of a request.
//   An arrival gives one result in the cycle after it is taken, and busy stays
//   low, so a new request may be taken every cycle.
//   A tick holds busy high while it stays in ST_TICK, releasing packets; its
//   results follow one per cycle, each emitted from ST_TICK through a register.
//   The pace of a tick is set by the queue memory's registered read: while
//   each head entry is checked against the token count and popped, the next is read.
//   Configuration: cfg_data is the bucket depth, written when cfg_valid and
//   cfg_ready are high; cfg_ready is high whenever busy is low.
//   Reset (rst_n low, synchronous) empties the queue, zeroes the token count
//   and sets the bucket depth to 10. No memory clearing pass is needed.
`include "assert_macros.svh"

module token_bucket_packet_shaper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tbps_pkg::tbps_in_t  in_req,
  output logic                out_strobe,
  output tbps_pkg::tbps_out_t out_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import tbps_pkg::*;

  tbps_mem_req_t      mem_req;
  logic [ENTRY_W-1:0] mem_rdata;

  tbps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mem_req   (mem_req),
    .mem_rdata (tbps_entry_t'(mem_rdata))
  );

  tbps_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .raddr(mem_req.raddr),
    .rdata(mem_rdata)
  );

  `ASSERT_CLK(a_take_responds, (start && !busy) |=> (out_strobe || busy), "request without response")
  `ASSERT_CLK(a_tick_emits, busy |=> out_strobe, "tick cycle emitted no result")
  `ASSERT_NEVER(a_write_in_tick, mem_req.we && busy, "queue written during a tick")
  `ASSERT_CLK(a_token_id_zero, (out_strobe && (out_res.event_res == EV_TOKEN_ADD || out_res.event_res == EV_TOKEN_DROP)) |-> (out_res.out_packet_id == '0), "token event with packet id")

endmodule

// ===== sim/tb_token_bucket_packet_shaper.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for token_bucket_packet_shaper: directed table, then random phases.
// Depends on tbps_pkg and the shaper RTL; a built-in shaper model predicts every result.
module tb_token_bucket_packet_shaper;
  import tbps_pkg::*;

  typedef struct {
    logic        kind;
    logic [15:0] id;
    logic [15:0] need;
    int          reps;
    bit          pin;
    tbps_ev_t    ev;
    logic [15:0] tok;
  } shaper_row_t;

  typedef struct {
    bit          pin;
    tbps_ev_t    ev;
    logic [15:0] tok;
  } shaper_pin_t;

  typedef struct {
    logic [15:0] depth;
    int          tick_pct;
    bit          idle_on;
    bit          pick_depth;
  } depth_phase_t;

  localparam int N_DIR       = 12;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 45;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  tbps_in_t    in_req = '0;
  logic        out_strobe;
  tbps_out_t   out_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // Shaper model state.
  logic [15:0] depth_q;
  logic [15:0] tok_cnt;
  tbps_entry_t shaper_wait [QUEUE_DEPTH];
  int          head_idx;
  int          tail_idx;
  int          fifo_fill;

  tbps_out_t   exp_res_q [$];
  shaper_pin_t pinned_q [$];
  bit          idle_on = 1'b1;
  int          fails = 0;
  int          req_cnt = 0;
  int          res_cnt = 0;
  int          depth_writes = 0;
  int          ev_seen [6] = '{default: 0};

  // The zero-need rows exercise immediate release and waiting behind another packet.
  shaper_row_t dir_rows [N_DIR] = '{
    '{1'b0, 16'hFFFF, 16'h0000, 1,  1'b1, EV_RELEASED,   16'd0},
    '{1'b0, 16'h0001, 16'd11,   1,  1'b1, EV_DROP_LARGE, 16'd0},
    '{1'b0, 16'h0000, 16'hFFFF, 1,  1'b1, EV_DROP_LARGE, 16'd0},
    '{1'b0, 16'hA5A5, 16'd3,    1,  1'b1, EV_QUEUED,     16'd0},
    '{1'b0, 16'h5A5A, 16'd0,    1,  1'b1, EV_QUEUED,     16'd0},
    '{1'b1, 16'hFFFF, 16'hFFFF, 1,  1'b1, EV_TOKEN_ADD,  16'd1},
    '{1'b1, 16'h0000, 16'h0000, 1,  1'b1, EV_TOKEN_ADD,  16'd2},
    '{1'b1, 16'h1234, 16'h0F0F, 1,  1'b0, EV_TOKEN_ADD,  16'd0},
    '{1'b0, 16'h00F0, 16'd1,    1,  1'b1, EV_QUEUED,     16'd0},
    '{1'b0, 16'h0100, 16'd0,    15, 1'b1, EV_QUEUED,     16'd0},
    '{1'b0, 16'h7FFF, 16'd1,    1,  1'b1, EV_DROP_FULL,  16'd0},
    '{1'b1, 16'h0F0F, 16'hF0F0, 1,  1'b0, EV_TOKEN_ADD,  16'd0}
  };

  // Depth 65535 lets tokens pile up so that the drop to 3 afterwards leaves the
  // count above the depth; the last phase is deep enough to free any blocked head.
  depth_phase_t phases [N_PHASES] = '{
    '{16'd0,     50, 1'b1, 1'b0},
    '{16'd65535, 75, 1'b1, 1'b0},
    '{16'd3,     50, 1'b0, 1'b0},
    '{16'd12,    40, 1'b1, 1'b0},
    '{16'd1,     50, 1'b1, 1'b0},
    '{16'd20,    55, 1'b1, 1'b0},
    '{16'd0,     50, 1'b1, 1'b1},
    '{16'd16,    60, 1'b1, 1'b0}
  };

  token_bucket_packet_shaper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void note_event(input tbps_ev_t ev, input logic [15:0] id);
    tbps_out_t res;
    res.event_res     = ev;
    res.out_packet_id = id;
    res.tokens_left   = tok_cnt;
    res.last          = 1'b0;
    exp_res_q.push_back(res);
  endfunction

  function automatic void pop_waiting();
    head_idx  = (head_idx + 1) % QUEUE_DEPTH;
    fifo_fill = fifo_fill - 1;
  endfunction

  function automatic void predict_shaper(input tbps_in_t r);
    tbps_entry_t head;
    int          n_rel;
    n_rel = 0;
    if (r.kind == 1'b0) begin
      if (r.tokens_needed > depth_q) begin
        note_event(EV_DROP_LARGE, r.packet_id);
      end else if (fifo_fill >= QUEUE_DEPTH) begin
        note_event(EV_DROP_FULL, r.packet_id);
      end else begin
        shaper_wait[tail_idx].need = r.tokens_needed;
        shaper_wait[tail_idx].id   = r.packet_id;
        tail_idx  = (tail_idx + 1) % QUEUE_DEPTH;
        fifo_fill = fifo_fill + 1;
        if (fifo_fill == 1 && tok_cnt >= r.tokens_needed) begin
          tok_cnt = tok_cnt - r.tokens_needed;
          pop_waiting();
          note_event(EV_RELEASED, r.packet_id);
        end else begin
          note_event(EV_QUEUED, r.packet_id);
        end
      end
    end else begin
      if (tok_cnt >= depth_q) begin
        note_event(EV_TOKEN_DROP, 16'd0);
      end else begin
        tok_cnt = tok_cnt + 16'd1;
        note_event(EV_TOKEN_ADD, 16'd0);
      end
      while (fifo_fill > 0 && n_rel < MAX_RELEASES) begin
        head = shaper_wait[head_idx];
        if (head.need > tok_cnt) break;
        tok_cnt = tok_cnt - head.need;
        pop_waiting();
        note_event(EV_RELEASED, head.id);
        n_rel++;
      end
    end
    exp_res_q[exp_res_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_result(input tbps_out_t got);
    tbps_out_t want;
    if (exp_res_q.size() == 0) begin
      $error("unexpected result: event %0d id %h tokens %0d", got.event_res,
             got.out_packet_id, got.tokens_left);
      fails++;
    end else begin
      want = exp_res_q.pop_front();
      if (got.event_res !== want.event_res) begin
        $error("event_res mismatch: expected %0d, actual %0d", want.event_res, got.event_res);
        fails++;
      end
      if (got.out_packet_id !== want.out_packet_id) begin
        $error("out_packet_id mismatch: expected %h, actual %h", want.out_packet_id,
               got.out_packet_id);
        fails++;
      end
      if (got.tokens_left !== want.tokens_left) begin
        $error("tokens_left mismatch: expected %0d, actual %0d", want.tokens_left,
               got.tokens_left);
        fails++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
        fails++;
      end
    end
    res_cnt++;
    if (got.event_res < 3'd6) ev_seen[got.event_res]++;
  endfunction

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin : shaper_monitor
    int          base;
    shaper_pin_t pin;
    if (!rst_n) begin
      depth_q   = DEPTH_RESET;
      tok_cnt   = '0;
      head_idx  = 0;
      tail_idx  = 0;
      fifo_fill = 0;
    end else begin
      if (out_strobe) check_result(out_res);
      if (cfg_valid && cfg_ready) depth_q = cfg_data;
      if (start && !busy) begin
        base = exp_res_q.size();
        predict_shaper(in_req);
        req_cnt++;
        if (pinned_q.size() != 0) begin
          pin = pinned_q.pop_front();
          if (pin.pin) begin
            exp_res_q[base].event_res   = pin.ev;
            exp_res_q[base].tokens_left = pin.tok;
          end
        end
      end
    end
  end

  task automatic send_request(input tbps_in_t r);
    while (idle_on && $urandom_range(99) < 8) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_depth(input logic [15:0] d);
    start <= 1'b0;
    @(posedge clk);
    while (exp_res_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    depth_writes++;
  endtask

  function automatic tbps_in_t rand_request(input int tick_pct, input logic [15:0] depth);
    tbps_in_t r;
    int       sel;
    int       cap;
    cap = (depth < 16'd8) ? int'(depth) : 8;
    sel = $urandom_range(99);
    r.kind          = ($urandom_range(99) < tick_pct);
    r.packet_id     = 16'($urandom_range(65535));
    r.tokens_needed = 16'($urandom_range(cap, 0));
    // Ticks carry noise in the ignored fields.
    if (r.kind) begin
      r.tokens_needed = 16'($urandom_range(65535));
    end else if (sel >= 80 && sel < 90 && depth <= 16'd64) begin
      r.tokens_needed = 16'($urandom_range(65535));
    end else if (sel >= 90 && depth <= 16'd12) begin
      r.tokens_needed = depth + 16'($urandom_range(1));
    end
    return r;
  endfunction

  initial begin : stimulus
    tbps_in_t    r;
    shaper_pin_t p;
    logic [15:0] d;
    int          w;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        r.kind          = dir_rows[i].kind;
        r.packet_id     = dir_rows[i].id + 16'(k);
        r.tokens_needed = dir_rows[i].need;
        p.pin = dir_rows[i].pin;
        p.ev  = dir_rows[i].ev;
        p.tok = dir_rows[i].tok;
        pinned_q.push_back(p);
        send_request(r);
      end
    end

    foreach (phases[i]) begin
      d = phases[i].pick_depth ? 16'($urandom_range(15, 2)) : phases[i].depth;
      write_depth(d);
      idle_on = phases[i].idle_on;
      repeat (PHASE_ITEMS) send_request(rand_request(phases[i].tick_pct, d));
    end

    start <= 1'b0;
    @(posedge clk);
    for (w = 0; w < 2000 && exp_res_q.size() != 0; w++) @(posedge clk);
    repeat (24) @(posedge clk);
    if (exp_res_q.size() != 0) begin
      $error("%0d expected results never arrived", exp_res_q.size());
      fails += exp_res_q.size();
    end

    $display("Covered %0d requests under %0d bucket depth writes, %0d results checked.",
             req_cnt, depth_writes, res_cnt);
    $display("Events: queued %0d, released %0d, too large %0d, queue full %0d, %s %0d/%0d",
             ev_seen[0], ev_seen[1], ev_seen[2], ev_seen[3], "token added/dropped",
             ev_seen[4], ev_seen[5]);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
